/* rtl/salsa20_stream_cipher_assert.svh */
// Assertion macros for the Salsa20 block
`ifndef SALSA20_STREAM_CIPHER_ASSERT_SVH
`define SALSA20_STREAM_CIPHER_ASSERT_SVH
`ifndef SYNTHESIS
`define S20_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define S20_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define S20_ASSERT(label, clk, rst, prop, msg)
`define S20_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

/* rtl/s20_pkg.sv */
`timescale 1ns / 1ps
package s20_pkg;
   localparam int unsigned CfgIdxWidth = 3;
   localparam int unsigned CfgDataWidth = 64;
   localparam logic [CfgIdxWidth-1:0] CFG_KEY01 = 3'd0;
   localparam logic [CfgIdxWidth-1:0] CFG_KEY23 = 3'd1;
   localparam logic [CfgIdxWidth-1:0] CFG_KEY45 = 3'd2;
   localparam logic [CfgIdxWidth-1:0] CFG_KEY67 = 3'd3;
   localparam logic [CfgIdxWidth-1:0] CFG_NONCE = 3'd4;
   localparam logic [CfgIdxWidth-1:0] CFG_LONG  = 3'd5;
   localparam logic [CfgIdxWidth-1:0] CFG_ROUNDS = 3'd6;
   localparam int unsigned QueueDepth = 2;

   typedef logic [15:0][31:0] block_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_message;
   } item_type;

   typedef struct packed {
      logic [63:0] key01;
      logic [63:0] key23;
      logic [63:0] key45;
      logic [63:0] key67;
      logic [63:0] nonce;
      logic        long_key;
      logic [3:0]  rounds;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic [63:0] counter;
   } core_req_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned r);
      rotl = (v << r) | (v >> (32 - r));
   endfunction

   function automatic block_type init_block(input cfg_type c, input logic [63:0] ctr);
      block_type b;
      logic [31:0] k0, k1, k2, k3;
      k0 = 32'h61707865;
      k3 = 32'h6b206574;
      k1 = c.long_key ? 32'h3320646e : 32'h3120646e;
      k2 = c.long_key ? 32'h79622d32 : 32'h79622d36;
      b[0] = k0;
      b[1] = c.key01[31:0];
      b[2] = c.key01[63:32];
      b[3] = c.key23[31:0];
      b[4] = c.key23[63:32];
      b[5] = k1;
      b[6] = c.nonce[31:0];
      b[7] = c.nonce[63:32];
      b[8] = ctr[31:0];
      b[9] = ctr[63:32];
      b[10] = k2;
      b[11] = c.long_key ? c.key45[31:0] : c.key01[31:0];
      b[12] = c.long_key ? c.key45[63:32] : c.key01[63:32];
      b[13] = c.long_key ? c.key67[31:0] : c.key23[31:0];
      b[14] = c.long_key ? c.key67[63:32] : c.key23[63:32];
      b[15] = k3;
      init_block = b;
   endfunction
endpackage

/* rtl/s20_core.sv */
`timescale 1ns / 1ps
// Keystream block builder: one quarter-round column or row (four QRs) per cycle
module s20_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  s20_pkg::cfg_type      cfg,
   input  logic [63:0]           counter,
   output logic                  busy,
   output logic                  done,
   output s20_pkg::block_type    keystream
);
   `include "salsa20_stream_cipher_assert.svh"

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_ADD  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [3:0] round_ff, round_in;
   logic       half_ff, half_in;
   s20_pkg::block_type init_ff, init_in, work_ff, work_in, ks_ff, ks_in;
   s20_pkg::block_type qr_out;

   function automatic logic [127:0] qr(input logic [31:0] a, b, c, d);
      logic [31:0] nb, nc, nd, na;
      nb = b ^ s20_pkg::rotl(a + d, 7);
      nc = c ^ s20_pkg::rotl(nb + a, 9);
      nd = d ^ s20_pkg::rotl(nc + nb, 13);
      na = a ^ s20_pkg::rotl(nd + nc, 18);
      qr = {na, nb, nc, nd};
   endfunction

   always_comb begin
      logic [127:0] r0, r1, r2, r3;
      qr_out = work_ff;
      if (!half_ff) begin
         r0 = qr(work_ff[0], work_ff[4], work_ff[8], work_ff[12]);
         r1 = qr(work_ff[5], work_ff[9], work_ff[13], work_ff[1]);
         r2 = qr(work_ff[10], work_ff[14], work_ff[2], work_ff[6]);
         r3 = qr(work_ff[15], work_ff[3], work_ff[7], work_ff[11]);
         {qr_out[0], qr_out[4], qr_out[8], qr_out[12]} = r0;
         {qr_out[5], qr_out[9], qr_out[13], qr_out[1]} = r1;
         {qr_out[10], qr_out[14], qr_out[2], qr_out[6]} = r2;
         {qr_out[15], qr_out[3], qr_out[7], qr_out[11]} = r3;
      end else begin
         r0 = qr(work_ff[0], work_ff[1], work_ff[2], work_ff[3]);
         r1 = qr(work_ff[5], work_ff[6], work_ff[7], work_ff[4]);
         r2 = qr(work_ff[10], work_ff[11], work_ff[8], work_ff[9]);
         r3 = qr(work_ff[15], work_ff[12], work_ff[13], work_ff[14]);
         {qr_out[0], qr_out[1], qr_out[2], qr_out[3]} = r0;
         {qr_out[5], qr_out[6], qr_out[7], qr_out[4]} = r1;
         {qr_out[10], qr_out[11], qr_out[8], qr_out[9]} = r2;
         {qr_out[15], qr_out[12], qr_out[13], qr_out[14]} = r3;
      end
   end

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      half_in = half_ff;
      init_in = init_ff;
      work_in = work_ff;
      ks_in = ks_ff;
      done = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               init_in = s20_pkg::init_block(cfg, counter);
               work_in = init_in;
               round_in = cfg.rounds;
               half_in = 1'b0;
               state_in = (cfg.rounds == 4'd0) ? ST_ADD : ST_RUN;
            end
         end
         ST_RUN: begin
            work_in = qr_out;
            half_in = !half_ff;
            if (half_ff) begin
               round_in = round_ff - 4'd1;
               if (round_ff == 4'd1) state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 16; i++) ks_in[i] = work_ff[i] + init_ff[i];
            done = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
         half_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         half_ff <= half_in;
      end
      init_ff <= init_in;
      work_ff <= work_in;
      ks_ff <= ks_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign keystream = ks_ff;

   `S20_ASSERT(a_run_rounds, clock, reset, (state_ff == ST_RUN) |-> (round_ff != 4'd0), "run with zero rounds")
   `S20_ASSERT(a_done_one, clock, reset, done |=> !done, "done held")
   `S20_ASSERT(a_start_idle, clock, reset, (start && !busy) |=> busy, "start ignored")
endmodule

/* rtl/s20_front.sv */
`timescale 1ns / 1ps
// Accepts items into a short queue
module s20_front #(
   parameter int unsigned Depth = s20_pkg::QueueDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  s20_pkg::item_type  in_item,
   output logic               q_valid,
   input  logic               q_pop,
   output s20_pkg::item_type  q_item
);
   `include "salsa20_stream_cipher_assert.svh"

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   s20_pkg::item_type mem_ff [Depth];
   logic [PtrW-1:0] wp_ff, rp_ff;
   logic [PtrW:0] cnt_ff;
   logic push, pop;

   assign in_ready = (cnt_ff != (PtrW+1)'(Depth));
   assign q_valid = (cnt_ff != '0);
   assign push = in_valid && in_ready;
   assign pop = q_pop && q_valid;
   assign q_item = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == PtrW'(Depth-1)) ? '0 : wp_ff + 1'b1;
         if (pop) rp_ff <= (rp_ff == PtrW'(Depth-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
      end
      if (push) mem_ff[wp_ff] <= in_item;
   end

   `S20_ASSERT(a_cnt_range, clock, reset, cnt_ff <= (PtrW+1)'(Depth), "queue overflow")
   `S20_ASSERT(a_cnt_step, clock, reset, (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1), "count slip")
   `S20_ASSERT(a_pop_nonempty, clock, reset, pop |-> (cnt_ff != '0), "pop when empty")
endmodule

/* rtl/s20_back.sv */
`timescale 1ns / 1ps
// Applies keystream bytes; starts a block build at byte position zero
module s20_back (
   input  logic               clock,
   input  logic               reset,
   input  s20_pkg::cfg_type   cfg,
   input  logic               q_valid,
   output logic               q_pop,
   input  s20_pkg::item_type  q_item,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [7:0]         out_byte
);
   `include "salsa20_stream_cipher_assert.svh"

   logic [63:0] ctr_ff, ctr_in;
   logic [5:0]  pos_ff, pos_in;
   logic        have_ff, have_in;
   logic        ov_ff;
   logic [7:0]  ob_ff;
   logic        core_start, core_busy, core_done;
   logic [63:0] eff_ctr;
   logic [5:0]  eff_pos;
   logic        slot_free;
   s20_pkg::block_type ks;
   logic [31:0] word;
   logic [7:0]  ksb;

   s20_core u_core (
      .clock(clock), .reset(reset), .start(core_start), .cfg(cfg),
      .counter(eff_ctr), .busy(core_busy), .done(core_done), .keystream(ks)
   );

   assign eff_ctr = q_item.start_message ? 64'd0 : ctr_ff;
   assign eff_pos = q_item.start_message ? 6'd0 : pos_ff;
   assign slot_free = !ov_ff || out_ready;
   // need a fresh block when position is zero and no block built for it yet
   assign core_start = q_valid && (eff_pos == 6'd0) && !have_ff && !core_busy && !core_done;
   assign q_pop = q_valid && slot_free && ((eff_pos != 6'd0) || have_ff);
   assign word = ks[eff_pos[5:2]];
   assign ksb = word[8*eff_pos[1:0] +: 8];

   always_comb begin
      ctr_in = ctr_ff;
      pos_in = pos_ff;
      have_in = have_ff || core_done;
      if (core_start && q_item.start_message) begin
         ctr_in = '0;
         pos_in = '0;
      end
      if (q_pop) begin
         pos_in = eff_pos + 6'd1;
         ctr_in = (eff_pos == 6'd63) ? eff_ctr + 64'd1 : eff_ctr;
         have_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff <= '0;
         pos_ff <= '0;
         have_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         ctr_ff <= ctr_in;
         pos_ff <= pos_in;
         have_ff <= have_in;
         if (q_pop) ov_ff <= 1'b1;
         else if (out_ready) ov_ff <= 1'b0;
      end
      if (q_pop) ob_ff <= q_item.data_byte ^ ksb;
   end

   assign out_valid = ov_ff;
   assign out_byte = ob_ff;

   `S20_ASSERT(a_pop_key, clock, reset, (q_pop && (eff_pos == 6'd0)) |-> have_ff, "byte without block")
   `S20_ASSERT(a_hold, clock, reset, (ov_ff && !out_ready) |=> ov_ff, "result dropped")
   `S20_ASSERT(a_no_start_busy, clock, reset, core_start |-> !core_busy, "start while busy")
endmodule

/* rtl/salsa20_stream_cipher.sv */
`timescale 1ns / 1ps
// Channel  Dir  Ports                  Contents
// req      in   req_tvalid/tready/..   tdata: data_byte; tuser: start_message
// rsp      out  rsp_tvalid/tready/..   tdata: out_byte
// csr      in   csr_we/index/wdata     seven registers, write only
// One byte a cycle within a keystream block while neither side stalls; a
// block build at each byte position zero runs one quarter-round column or
// row per cycle in the core, so the first byte of a block waits.
// Synchronous active-high reset clears counter, position and queue.
// Either side may stall; a two-entry queue parts acceptance from processing.
module salsa20_stream_cipher #(
   parameter int unsigned QueueDepth = s20_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] start_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   input  logic        csr_we,
   input  logic [s20_pkg::CfgIdxWidth-1:0]  csr_index,
   input  logic [s20_pkg::CfgDataWidth-1:0] csr_wdata
);
   s20_pkg::cfg_type  cfg_ff;
   s20_pkg::item_type in_item, q_item;
   logic q_valid, q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key01 <= '0;
         cfg_ff.key23 <= '0;
         cfg_ff.key45 <= '0;
         cfg_ff.key67 <= '0;
         cfg_ff.nonce <= '0;
         cfg_ff.long_key <= 1'b1;
         cfg_ff.rounds <= 4'd10;
      end else if (csr_we) begin
         unique case (csr_index)
            s20_pkg::CFG_KEY01:  cfg_ff.key01 <= csr_wdata;
            s20_pkg::CFG_KEY23:  cfg_ff.key23 <= csr_wdata;
            s20_pkg::CFG_KEY45:  cfg_ff.key45 <= csr_wdata;
            s20_pkg::CFG_KEY67:  cfg_ff.key67 <= csr_wdata;
            s20_pkg::CFG_NONCE:  cfg_ff.nonce <= csr_wdata;
            s20_pkg::CFG_LONG:   cfg_ff.long_key <= csr_wdata[0];
            s20_pkg::CFG_ROUNDS: cfg_ff.rounds <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   assign in_item.data_byte = req_tdata;
   assign in_item.start_message = req_tuser;

   s20_front #(.Depth(QueueDepth)) u_front (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
   );

   s20_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .q_valid(q_valid), .q_pop(q_pop),
      .q_item(q_item), .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_byte(rsp_tdata)
   );
endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
   import s20_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] data_byte
   logic        req_tuser;    // [0] start_message
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;    // [7:0] out_byte
   logic        csr_we;
   logic [CfgIdxWidth-1:0]  csr_index;
   logic [CfgDataWidth-1:0] csr_wdata;

   salsa20_stream_cipher DUT (.*);

   // shadow of the cipher state
   logic [63:0] shadow_reg [0:6];
   logic [63:0] blk_counter;
   logic [5:0]  byte_pos;
   logic [31:0] ks_words [0:15];

   logic [7:0] expected_bytes [$];
   int errors;
   int send_idle_pct;
   int recv_stall_pct;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic [31:0] rol32(input logic [31:0] v, input int r);
      return (v << r) | (v >> (32 - r));
   endfunction

   task automatic qround(inout logic [31:0] w [0:15], input int a, b, c, d);
      w[b] ^= rol32(w[a] + w[d], 7);
      w[c] ^= rol32(w[b] + w[a], 9);
      w[d] ^= rol32(w[c] + w[b], 13);
      w[a] ^= rol32(w[d] + w[c], 18);
   endtask

   task automatic build_keystream();
      logic [31:0] init [0:15];
      logic [31:0] w [0:15];
      logic        lk;
      lk = shadow_reg[CFG_LONG][0];
      init[0]  = 32'h61707865;
      init[5]  = lk ? 32'h3320646e : 32'h3120646e;
      init[10] = lk ? 32'h79622d32 : 32'h79622d36;
      init[15] = 32'h6b206574;
      init[1]  = shadow_reg[CFG_KEY01][31:0];
      init[2]  = shadow_reg[CFG_KEY01][63:32];
      init[3]  = shadow_reg[CFG_KEY23][31:0];
      init[4]  = shadow_reg[CFG_KEY23][63:32];
      init[6]  = shadow_reg[CFG_NONCE][31:0];
      init[7]  = shadow_reg[CFG_NONCE][63:32];
      init[8]  = blk_counter[31:0];
      init[9]  = blk_counter[63:32];
      init[11] = lk ? shadow_reg[CFG_KEY45][31:0]  : init[1];
      init[12] = lk ? shadow_reg[CFG_KEY45][63:32] : init[2];
      init[13] = lk ? shadow_reg[CFG_KEY67][31:0]  : init[3];
      init[14] = lk ? shadow_reg[CFG_KEY67][63:32] : init[4];
      w = init;
      for (int r = 0; r < shadow_reg[CFG_ROUNDS][3:0]; r++) begin
         qround(w, 0, 4, 8, 12);
         qround(w, 5, 9, 13, 1);
         qround(w, 10, 14, 2, 6);
         qround(w, 15, 3, 7, 11);
         qround(w, 0, 1, 2, 3);
         qround(w, 5, 6, 7, 4);
         qround(w, 10, 11, 8, 9);
         qround(w, 15, 12, 13, 14);
      end
      for (int i = 0; i < 16; i++) ks_words[i] = w[i] + init[i];
   endtask

   task automatic predict_cipher_byte(input logic [7:0] data, input logic start);
      logic [31:0] word;
      if (start) begin
         blk_counter = '0;
         byte_pos = '0;
      end
      if (byte_pos == 6'd0) build_keystream();
      word = ks_words[byte_pos[5:2]];
      expected_bytes.push_back(data ^ word[byte_pos[1:0]*8 +: 8]);
      byte_pos = byte_pos + 6'd1;
      if (byte_pos == 6'd0) blk_counter = blk_counter + 64'd1;
   endtask

   task automatic report_mismatch(input logic [7:0] got, input logic [7:0] want);
      $display("mismatch at %0t: out_byte %h, expected %h", $realtime, got, want);
      errors++;
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               $display("unexpected transfer at %0t: out_byte %h", $realtime, rsp_tdata);
               errors++;
            end else begin
               logic [7:0] want;
               want = expected_bytes.pop_front();
               if (rsp_tdata !== want) report_mismatch(rsp_tdata, want);
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_byte(input logic [7:0] data, input logic start);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_cipher_byte(data, start);
   endtask

   task automatic drain();
      int guard;
      req_tvalid <= 1'b0;
      guard = 0;
      while (expected_bytes.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      if (guard >= 200000) begin
         $display("Simulation FAILED");
         $finish;
      end
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [63:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CFG_LONG) shadow_reg[idx] = val & 64'h1;
      else if (idx == CFG_ROUNDS) shadow_reg[idx] = val & 64'hf;
      else shadow_reg[idx] = val;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic configure(input logic [63:0] key_fill, input logic lk, input logic [3:0] dr);
      drain();
      write_reg(CFG_KEY01, key_fill == '1 ? '1 : rand64());
      write_reg(CFG_KEY23, key_fill == '1 ? '1 : rand64());
      write_reg(CFG_KEY45, key_fill == '1 ? '1 : rand64());
      write_reg(CFG_KEY67, key_fill == '1 ? '1 : rand64());
      write_reg(CFG_NONCE, key_fill == '1 ? '1 : rand64());
      write_reg(CFG_LONG, 64'(lk));
      write_reg(CFG_ROUNDS, 64'(dr));
   endtask

   task automatic test_reset_defaults();
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h5a, 1'b0);
   endtask

   task automatic test_directed();
      configure('1, 1'b0, 4'd0);
      for (int i = 0; i < 6; i++) send_byte(i[0] ? 8'hff : 8'h00, i == 0);
      configure('0, 1'b1, 4'd15);
      for (int i = 0; i < 6; i++) send_byte(8'($urandom_range(255)), i == 3);
      configure('0, 1'b1, 4'd4);
      // first byte with the start flag, then a restart mid-block
      for (int i = 0; i < 8; i++) send_byte(8'ha5, i == 0 || i == 5);
   endtask

   task automatic test_random_messages(input int n);
      int sent;
      sent = 0;
      while (sent < n) begin
         int len;
         len = ($urandom_range(9) == 0) ? $urandom_range(200, 140) : $urandom_range(70, 1);
         for (int i = 0; i < len && sent < n; i++) begin
            send_byte(8'($urandom_range(255)), i == 0 || $urandom_range(99) == 0);
            sent++;
         end
      end
   endtask

   task automatic test_phase(input int sidle, input int rstall, input logic lk,
                             input logic [3:0] dr, input int n);
      configure('0, lk, dr);
      send_idle_pct = sidle;
      recv_stall_pct = rstall;
      test_random_messages(n);
   endtask

   initial begin
      errors = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      for (int i = 0; i < 7; i++) shadow_reg[i] = '0;
      shadow_reg[CFG_LONG] = 64'd1;
      shadow_reg[CFG_ROUNDS] = 64'd10;
      blk_counter = '0;
      byte_pos = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_directed();
      test_phase(0, 0, 1'b1, 4'd10, 400);
      test_phase(82, 0, 1'b0, 4'd6, 250);
      test_phase(0, 82, 1'b1, 4'd4, 250);
      test_phase(38, 38, 1'b0, 4'd10, 400);
      test_phase(0, 0, 1'b1, 4'd1, 200);
      test_phase(38, 0, 1'b0, 4'd15, 200);
      drain();

      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
